### design/gaussian_log_prob_entropy_top_defines.svh
// Assertion macros used by the block's top module.
`ifndef GAUSSIAN_LOG_PROB_ENTROPY_TOP_DEFINES_SVH
`define GAUSSIAN_LOG_PROB_ENTROPY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define GLPE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define GLPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
// Implication after a fixed number of cycles
`define GLPE_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
		else $error("assertion failed");
`else
`define GLPE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define GLPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define GLPE_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons)
`endif

`endif

### design/glpe_pkg.sv
package glpe_pkg;

	// Restoring divider steps, one quotient bit per cell
	localparam int DIV_STEPS = 32;
	// Register stages in the log unit
	localparam int LOG_LAT = 6;

	// ln 2 in Q28, ln sqrt(2 pi) and 0.5 + ln sqrt(2 pi) in Q30
	localparam longint LN2_Q28 = 64'sd186065279;
	localparam longint LNSQ_Q30 = 64'sd986702737;
	localparam longint ENT_Q30 = 64'sd1523573649;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic signed [31:0] mean;
		logic signed [31:0] std_dev;
	} in_t;

	typedef struct packed {
		logic signed [31:0] log_density;
		logic signed [31:0] entropy;
		logic bad_sigma;
	} res_t;

	// Data handed from one divider cell to the next
	typedef struct packed {
		logic [30:0] rem;
		logic [31:0] w;
		logic [30:0] den;
	} div_t;

	// Log unit results: entropy and the constant part of the log density
	typedef struct packed {
		logic [31:0] ent;
		logic signed [39:0] cst;
	} lg_t;

	// Saturate to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// log2(1 + i / 2^tb) in Q30 by repeated squaring, elaboration only
	function automatic logic [30:0] log_entry(input int unsigned i, input int unsigned tb);
		logic [63:0] x;
		logic [30:0] r;
		r = '0;
		if (i >= (32'd1 << tb))
			return 31'h4000_0000;
		x = (64'd1 << 30) + (64'(i) << (30 - tb));
		for (int k = 1; k <= 30; k++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[30 - k] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

### design/gaussian_log_prob_entropy_top.sv
// Gaussian log density and entropy, one element per transfer. An item is taken on
// every cycle with start high (busy stays low); its result appears with done high
// exactly 35 cycles later, for one cycle, and must be taken then: there is no
// backpressure. The latency is set by the 32-cell restoring divider chain that
// forms |x - mu| / sigma, one quotient bit per cell; the log unit runs alongside.
`include "gaussian_log_prob_entropy_top_defines.svh"

module gaussian_log_prob_entropy_top #(
	parameter int FRAC_BITS      = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  glpe_pkg::in_t  item,
	output logic           done,
	output glpe_pkg::res_t result
);
	import glpe_pkg::*;

	localparam int LG_DLY = DIV_STEPS - LOG_LAT;
	localparam int LAT    = DIV_STEPS + 3;

	typedef struct packed {
		logic v;
		logic bad;
		logic ovf;
	} side_t;

	assign busy = 1'b0;

	// Front stage: difference, magnitude, overflow and sigma checks
	logic signed [32:0] dif;
	logic [32:0]        t;
	logic [32:0]        t_s1;
	logic [30:0]        sg_s1;
	side_t              side_q [0:DIV_STEPS];

	assign dif = {item.sample_value[31], item.sample_value} - {item.mean[31], item.mean};
	assign t   = dif[32] ? 33'(-dif) : 33'(dif);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++)
				side_q[k] <= '0;
		end else begin
			side_q[0].v   <= start & ~busy;
			side_q[0].bad <= item.std_dev[31] | (item.std_dev == '0);
			side_q[0].ovf <= {15'd0, t} >= {1'b0, item.std_dev[30:0], 16'd0};
			for (int k = 1; k <= DIV_STEPS; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		t_s1  <= t;
		sg_s1 <= item.std_dev[30:0];
	end

	// Divider chain
	div_t chain [0:DIV_STEPS];
	assign chain[0].rem = 31'(t_s1 >> 16);
	assign chain[0].w   = {t_s1[15:0], 16'd0};
	assign chain[0].den = sg_s1;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
		glpe_div_cell u_cell (
			.clk (clk),
			.d   (chain[k]),
			.q   (chain[k+1])
		);
	end

	// Log unit and its alignment line
	lg_t lg_out;
	lg_t lg_q [1:LG_DLY];

	glpe_log_unit #(
		.FRAC_BITS      (FRAC_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_log (
		.clk (clk),
		.sig (sg_s1),
		.res (lg_out)
	);

	always_ff @(posedge clk) begin
		lg_q[1] <= lg_out;
		for (int k = 2; k <= LG_DLY; k++)
			lg_q[k] <= lg_q[k-1];
	end

	// Squaring stage
	side_t       side_sq;
	lg_t         lg_sq;
	logic [63:0] qq_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_sq <= '0;
		else
			side_sq <= side_q[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		lg_sq <= lg_q[LG_DLY];
		qq_sq <= 64'(chain[DIV_STEPS].w) * 64'(chain[DIV_STEPS].w);
	end

	// Final sum, saturation and special cases
	logic [63:0]        term;
	logic signed [63:0] ld_sum;
	res_t               res_d;

	assign term   = qq_sq >> (33 - FRAC_BITS);
	assign ld_sum = 64'(lg_sq.cst) - signed'(term);

	always_comb begin
		res_d.bad_sigma = side_sq.bad;
		if (side_sq.bad) begin
			res_d.log_density = '0;
			res_d.entropy     = '0;
		end else begin
			res_d.entropy     = lg_sq.ent;
			res_d.log_density = side_sq.ovf ? 32'h8000_0000 : sat32(ld_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= side_sq.v;
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

	// Checks
	`GLPE_ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LAT, done)
	`GLPE_ASSERT_NOW(a_bad_zero, clk, arst_n, done && result.bad_sigma, result.log_density == '0 && result.entropy == '0)
	`GLPE_ASSERT_NEXT(a_ovf_min, clk, arst_n, side_sq.v && side_sq.ovf && !side_sq.bad, result.log_density == 32'h8000_0000)

endmodule

### design/glpe_div_cell.sv
module glpe_div_cell (
	input  logic           clk,
	input  glpe_pkg::div_t d,
	output glpe_pkg::div_t q
);
	import glpe_pkg::*;

	logic [31:0] r2;
	logic        ge;

	// One restoring step: bring in the next dividend bit, trial subtract
	assign r2 = {d.rem, d.w[31]};
	assign ge = r2 >= {1'b0, d.den};

	always_ff @(posedge clk) begin
		q.rem <= ge ? 31'(r2 - {1'b0, d.den}) : r2[30:0];
		q.w   <= {d.w[30:0], ge};
		q.den <= d.den;
	end

endmodule

### design/glpe_log_unit.sv
module glpe_log_unit #(
	parameter int FRAC_BITS      = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic          clk,
	input  logic [30:0]   sig,
	output glpe_pkg::lg_t res
);
	import glpe_pkg::*;

	localparam int T     = LOG_TABLE_BITS;
	localparam int SH    = 30 - LOG_TABLE_BITS;
	localparam int TAB_N = 1 << LOG_TABLE_BITS;
	localparam int S     = 30 - FRAC_BITS;
	localparam longint RND = longint'(1) << (S - 1);

	logic [30:0] lut [0:TAB_N];

	// Constant table of log2 over the mantissa range
	for (genvar g = 0; g <= TAB_N; g++) begin : g_lut
		assign lut[g] = log_entry(g, LOG_TABLE_BITS);
	end

	// Leading-one normalisation
	logic [30:0] nv;
	logic [4:0]  lz;
	always_comb begin
		nv = sig;
		lz = '0;
		if (nv[30:15] == '0) begin
			nv = nv << 16;
			lz[4] = 1'b1;
		end
		if (nv[30:23] == '0) begin
			nv = nv << 8;
			lz[3] = 1'b1;
		end
		if (nv[30:27] == '0) begin
			nv = nv << 4;
			lz[2] = 1'b1;
		end
		if (nv[30:29] == '0) begin
			nv = nv << 2;
			lz[1] = 1'b1;
		end
		if (nv[30] == 1'b0) begin
			nv = nv << 1;
			lz[0] = 1'b1;
		end
	end

	logic [4:0]    p_s1, p_s2, p_s3;
	logic [T-1:0]  idx_s1;
	logic [SH-1:0] rem_s1, rem_s2;
	logic [30:0]   a_s2, dif_s2, l_s3;
	logic signed [63:0] hi_s4, lo_s4;
	logic signed [39:0] lns_s5;

	logic [T:0]        bidx;
	logic [30+SH:0]    prod;
	logic signed [6:0] pf;
	logic signed [63:0] sum5, lns64, ent_sum, cst_sum;

	assign bidx = {1'b0, idx_s1} + 1'b1;
	assign prod = (31 + SH)'(dif_s2) * (31 + SH)'(rem_s2);
	assign pf   = signed'({2'b00, p_s3}) - 7'(FRAC_BITS);
	assign sum5 = (hi_s4 <<< 30) + lo_s4 + 64'sd134217728;
	assign lns64   = 64'(lns_s5);
	assign ent_sum = ENT_Q30 + lns64 + RND;
	assign cst_sum = -(lns64 + LNSQ_Q30) + RND;

	always_ff @(posedge clk) begin
		// mantissa split into table index and interpolation weight
		p_s1   <= 5'd30 - lz;
		idx_s1 <= nv[29 -: T];
		rem_s1 <= nv[SH-1:0];
		// table reads
		p_s2   <= p_s1;
		a_s2   <= lut[idx_s1];
		dif_s2 <= lut[bidx] - lut[idx_s1];
		rem_s2 <= rem_s1;
		// linear interpolation
		p_s3   <= p_s2;
		l_s3   <= a_s2 + 31'(prod >> SH);
		// scale log2 by ln 2, integer and fraction parts apart
		hi_s4  <= 64'(pf) * LN2_Q28;
		lo_s4  <= signed'(64'(l_s3)) * LN2_Q28;
		// round to Q30
		lns_s5 <= 40'(sum5 >>> 28);
		// constants added, rounded to the output format
		res.ent <= sat32(ent_sum >>> S);
		res.cst <= 40'(cst_sum >>> S);
	end

endmodule

### dv/gaussian_log_prob_entropy_top_tb.sv
`timescale 1ns / 1ps

module gaussian_log_prob_entropy_top_tb;
	import glpe_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int TBL_BITS = 8;
	localparam int RESULT_LATENCY = 35;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t item;
	logic done;
	res_t result;

	res_t density_queue[$];
	logic [63:0] ln_table [0:(1 << TBL_BITS)];
	int gap_pct;
	bit failed;
	int idle_cycles;

	gaussian_log_prob_entropy_top #(
		.FRAC_BITS(FRAC_BITS),
		.LOG_TABLE_BITS(TBL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor division by 2^k of a signed value
	function automatic longint floor_div_pow2(input longint v, input int k);
		return v >>> k;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// log2(1 + i/2^T) in Q30 by repeated squaring
	function automatic logic [63:0] log2_frac_q30(input int i);
		logic [63:0] x;
		logic [63:0] r;
		r = 0;
		if (i >= (1 << TBL_BITS))
			return 64'd1 << 30;
		x = (64'd1 << 30) + (64'(i) << (30 - TBL_BITS));
		for (int k = 1; k <= 30; k++) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[30 - k] = 1'b1;
			end
		end
		return r;
	endfunction

	// natural log of sigma in Q30, table plus linear interpolation
	function automatic longint ln_sigma_q30(input logic [63:0] s);
		int p;
		int sh;
		logic [63:0] m, frac, idx, rem, a, b, l;
		longint lg2;
		sh = 30 - TBL_BITS;
		p = 0;
		while (p < 31 && (s >> (p + 1)) != 0)
			p++;
		m = s << (30 - p);
		frac = m - (64'd1 << 30);
		idx = frac >> sh;
		rem = frac & ((64'd1 << sh) - 1);
		a = ln_table[idx];
		b = ln_table[idx + 1];
		l = a + (((b - a) * rem) >> sh);
		lg2 = (longint'(p) - FRAC_BITS) * (64'sd1 << 30) + longint'(l);
		return floor_div_pow2(lg2 * LN2_Q28 + (64'sd1 << 27), 28);
	endfunction

	function automatic longint q30_to_q16(input longint v);
		return floor_div_pow2(v + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
	endfunction

	function automatic res_t predict_density(input in_t it);
		res_t r;
		longint x, mu, sg, lns, d, term;
		logic [63:0] t, q;
		x = it.sample_value;
		mu = it.mean;
		sg = it.std_dev;
		r = '0;
		if (sg <= 0) begin
			r.bad_sigma = 1'b1;
			return r;
		end
		lns = ln_sigma_q30(sg);
		r.entropy = 32'(clamp32(q30_to_q16(ENT_Q30 + lns)));
		d = x - mu;
		t = (d < 0) ? -d : d;
		q = (t << 16) / sg;
		if (q >= (64'd1 << 32)) begin
			r.log_density = 32'h8000_0000;
		end else begin
			term = longint'((q * q) >> (33 - FRAC_BITS));
			r.log_density = 32'(clamp32(q30_to_q16(-(lns + LNSQ_Q30)) - term));
		end
		return r;
	endfunction

	// one transfer; start held across back-to-back items
	task automatic send_item(input in_t it);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		density_queue.push_back(predict_density(it));
		@(negedge clk);
	endtask

	task automatic release_bus();
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		release_bus();
		while (density_queue.size() != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 5) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_sigma();
		case ($urandom_range(4))
			0: return $urandom_range(1, 255);
			1: return $urandom_range(65536 >> 4, 65536 << 4);
			2: return $urandom;
			default: return $urandom_range(1, 32'h7fff_ffff);
		endcase
	endfunction

	function automatic in_t rand_item();
		in_t it;
		it.sample_value = $urandom;
		it.mean = ($urandom_range(1)) ? it.sample_value + $signed($urandom_range(0, 1 << 20))
			- (1 << 19) : $urandom;
		it.std_dev = ($urandom_range(19) == 0) ? $urandom : rand_sigma();
		return it;
	endfunction

	task automatic test_directed();
		logic [31:0] v[6];
		in_t it;
		v = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 32'h0001_0000};
		foreach (v[i]) begin
			it.sample_value = v[i];
			it.mean = v[5 - i];
			it.std_dev = v[(i + 1) % 6];
			send_item(it);
		end
		// smallest sigma with a large gap: ratio overflows
		send_item('{32'h7fff_ffff, 32'h8000_0000, 32'd1});
		// largest sigma
		send_item('{32'h0, 32'h0, 32'h7fff_ffff});
		// unit sigma at the mean
		send_item('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
		// negative and most negative sigma
		send_item('{32'h1234_5678, 32'h0, 32'hffff_0000});
		send_item('{32'h0, 32'h1, 32'h8000_0000});
		// sigma at table boundaries
		send_item('{32'h0003_0000, 32'h0, 32'h0001_ff00});
		send_item('{32'hfffd_0000, 32'h0, 32'h0000_ffff});
	endtask

	task automatic test_random(input int count, input int pct);
		gap_pct = pct;
		for (int n = 0; n < count; n++)
			send_item(rand_item());
	endtask

	// every result checked against the oldest expectation
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && done) begin
			if (density_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				failed = 1'b1;
			end else begin
				exp_r = density_queue.pop_front();
				if (result.log_density !== exp_r.log_density)
					$display("%0t: log_density expected %h actual %h", $time,
						exp_r.log_density, result.log_density);
				if (result.entropy !== exp_r.entropy)
					$display("%0t: entropy expected %h actual %h", $time,
						exp_r.entropy, result.entropy);
				if (result.bad_sigma !== exp_r.bad_sigma)
					$display("%0t: bad_sigma expected %b actual %b", $time,
						exp_r.bad_sigma, result.bad_sigma);
				if (result !== exp_r)
					failed = 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i <= (1 << TBL_BITS); i++)
			ln_table[i] = log2_frac_q30(i);
		failed = 1'b0;
		idle_cycles = 0;
		gap_pct = 0;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_random(370, 27);
		wait_drained();
		test_random(370, 68);
		test_random(370, 0);
		wait_drained();
		if (!failed) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
